// ----- hw/rtl/mgm_pkg.sv -----
// Shared types, S-box table and round helpers for the Magma cipher pipeline.
// No dependencies; used by mgm_key_regs, mgm_round and the top level.
`default_nettype none

package mgm_pkg;

    localparam int unsigned NUM_ROUNDS = 32;
    localparam int unsigned NUM_KEYS   = 8;
    localparam int unsigned ROT_LEFT   = 11;

    // Register indexes of the key words
    typedef enum logic [3:0] {
        REG_KEY_0 = 4'd0,
        REG_KEY_1 = 4'd1,
        REG_KEY_2 = 4'd2,
        REG_KEY_3 = 4'd3,
        REG_KEY_4 = 4'd4,
        REG_KEY_5 = 4'd5,
        REG_KEY_6 = 4'd6,
        REG_KEY_7 = 4'd7
    } t_reg_index;

    typedef logic [NUM_KEYS-1:0][31:0] t_key_set;

    // One block in flight: operation and the two halves
    typedef struct packed {
        logic        func;
        logic [31:0] lo;
        logic [31:0] hi;
    } t_beat;

    localparam logic [3:0] SBOX [8][16] = '{
        '{4'hc, 4'h4, 4'h6, 4'h2, 4'ha, 4'h5, 4'hb, 4'h9,
          4'he, 4'h8, 4'hd, 4'h7, 4'h0, 4'h3, 4'hf, 4'h1},
        '{4'h6, 4'h8, 4'h2, 4'h3, 4'h9, 4'ha, 4'h5, 4'hc,
          4'h1, 4'he, 4'h4, 4'h7, 4'hb, 4'hd, 4'h0, 4'hf},
        '{4'hb, 4'h3, 4'h5, 4'h8, 4'h2, 4'hf, 4'ha, 4'hd,
          4'he, 4'h1, 4'h7, 4'h4, 4'hc, 4'h9, 4'h6, 4'h0},
        '{4'hc, 4'h8, 4'h2, 4'h1, 4'hd, 4'h4, 4'hf, 4'h6,
          4'h7, 4'h0, 4'ha, 4'h5, 4'h3, 4'he, 4'h9, 4'hb},
        '{4'h7, 4'hf, 4'h5, 4'ha, 4'h8, 4'h1, 4'h6, 4'hd,
          4'h0, 4'h9, 4'h3, 4'he, 4'hb, 4'h4, 4'h2, 4'hc},
        '{4'h5, 4'hd, 4'hf, 4'h6, 4'h9, 4'h2, 4'hc, 4'ha,
          4'hb, 4'h7, 4'h8, 4'h1, 4'h4, 4'h3, 4'he, 4'h0},
        '{4'h8, 4'he, 4'h2, 4'h5, 4'h6, 4'h9, 4'h1, 4'hc,
          4'hf, 4'h4, 4'hb, 4'h0, 4'hd, 4'ha, 4'h3, 4'h7},
        '{4'h1, 4'h7, 4'he, 4'hd, 4'h0, 4'h5, 4'h8, 4'h3,
          4'h4, 4'hf, 4'ha, 4'h6, 4'h9, 4'hc, 4'hb, 4'h2}
    };

    // Round function: add key, substitute each nibble, rotate left by 11
    function automatic logic [31:0] g_round(logic [31:0] k, logic [31:0] x);
        logic [31:0] s;
        logic [31:0] t;
        s = x + k;
        for (int i = 0; i < 8; i++) begin
            t[4*i +: 4] = SBOX[i][s[4*i +: 4]];
        end
        return {t[31-ROT_LEFT:0], t[31:32-ROT_LEFT]};
    endfunction

    // Key schedule: forward order in the first three passes when encrypting,
    // only in the first pass when decrypting; reversed order otherwise
    function automatic logic [2:0] key_index(logic [4:0] round, logic dec);
        logic [1:0] pass;
        logic       fwd;
        pass = round[4:3];
        fwd  = dec ? (pass == 2'd0) : (pass != 2'd3);
        return fwd ? round[2:0] : ~round[2:0];
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/mgm_key_regs.sv -----
// Key word register file written through the configuration port.
// Depends on mgm_pkg for the key set type and register indexes.
`default_nettype none

module mgm_key_regs (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [3:0]        i_cfg_index,
    input  wire logic [31:0]       i_cfg_data,
    output mgm_pkg::t_key_set      o_keys
);

    mgm_pkg::t_key_set r_keys;
    mgm_pkg::t_key_set n_keys;

    assign o_cfg_ready = 1'b1;
    assign o_keys      = r_keys;

    // Decode the index; drop writes beyond the last key word
    always_comb begin
        n_keys = r_keys;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                mgm_pkg::REG_KEY_0: n_keys[0] = i_cfg_data;
                mgm_pkg::REG_KEY_1: n_keys[1] = i_cfg_data;
                mgm_pkg::REG_KEY_2: n_keys[2] = i_cfg_data;
                mgm_pkg::REG_KEY_3: n_keys[3] = i_cfg_data;
                mgm_pkg::REG_KEY_4: n_keys[4] = i_cfg_data;
                mgm_pkg::REG_KEY_5: n_keys[5] = i_cfg_data;
                mgm_pkg::REG_KEY_6: n_keys[6] = i_cfg_data;
                mgm_pkg::REG_KEY_7: n_keys[7] = i_cfg_data;
                default:            n_keys    = r_keys;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keys <= '0;
        end else begin
            r_keys <= n_keys;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/mgm_round.sv -----
// One Feistel round of the cipher with its own output register and valid bit.
// Depends on mgm_pkg for the beat type, round function and key schedule.
`default_nettype none

module mgm_round #(
    parameter int unsigned ROUND = 0
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire mgm_pkg::t_beat    i_beat,
    input  wire mgm_pkg::t_key_set i_keys,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output mgm_pkg::t_beat         o_beat
);

    logic           r_valid;
    mgm_pkg::t_beat r_beat;
    mgm_pkg::t_beat n_beat;
    logic [31:0]    key;

    // Take a new beat when empty or when the held one moves on
    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_beat  = r_beat;

    // Even rounds write the high half, odd rounds the low half
    always_comb begin
        key    = i_keys[mgm_pkg::key_index(5'(ROUND), i_beat.func)];
        n_beat = i_beat;
        if ((ROUND % 2) == 0) begin
            n_beat.hi = i_beat.hi ^ mgm_pkg::g_round(key, i_beat.lo);
        end else begin
            n_beat.lo = i_beat.lo ^ mgm_pkg::g_round(key, i_beat.hi);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Load the payload only with an incoming beat; hold it otherwise
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_beat <= n_beat;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/magma_block_cipher_top.sv -----
// Top level of the Magma 64-bit block cipher: key registers and 32 round stages.
// Depends on mgm_pkg, mgm_key_regs and mgm_round.
`default_nettype none

// Magma (GOST R 34.12-2015) block cipher engine. One 64-bit block enters per
// clock while o_in_stall is low; throughput is one block per cycle unless the
// output stalls. Each of the 32 pipeline stages holds one Feistel round (a
// 32-bit key add, eight 4-bit S-boxes and an XOR), and that round sets the clock
// period. Every stage keeps its own valid bit, so a stall at the output fills
// the bubbles behind it before the input is stalled. Key words are written
// through the configuration port, which is always ready; write them only while
// no block is in flight. i_func selects encrypt (0) or decrypt (1) per block.

module magma_block_cipher_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic        i_func,
    input  wire logic [63:0] i_data_block,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [63:0]      o_result_block,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [3:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);

    localparam int unsigned NR = mgm_pkg::NUM_ROUNDS;

    mgm_pkg::t_key_set keys;
    logic              stg_valid [NR+1];
    logic              stg_ready [NR+1];
    mgm_pkg::t_beat    stg_beat  [NR+1];

    mgm_key_regs u_keys (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_keys      (keys)
    );

    // Split the incoming block into halves
    assign stg_valid[0]     = i_in_valid;
    assign stg_beat[0].func = i_func;
    assign stg_beat[0].lo   = i_data_block[31:0];
    assign stg_beat[0].hi   = i_data_block[63:32];
    assign o_in_stall       = !stg_ready[0];

    for (genvar g = 0; g < NR; g++) begin : g_round
        mgm_round #(
            .ROUND (g)
        ) u_round (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (stg_valid[g]),
            .o_ready (stg_ready[g]),
            .i_beat  (stg_beat[g]),
            .i_keys  (keys),
            .o_valid (stg_valid[g+1]),
            .i_ready (stg_ready[g+1]),
            .o_beat  (stg_beat[g+1])
        );
    end

    // Last round wrote the low half, which goes out high
    assign stg_ready[NR]  = !i_out_stall;
    assign o_out_valid    = stg_valid[NR];
    assign o_result_block = {stg_beat[NR].lo, stg_beat[NR].hi};

`ifndef SYNTHESIS
    // Input stalls only when the first stage is full and blocked
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (stg_valid[1] && !stg_ready[1]))
        else $error("input stalled with room in first stage");

    // An accepted block lands in the first stage
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> stg_valid[1])
        else $error("accepted block lost at first stage");

    // A stalled result is not dropped
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_result_block)))
        else $error("stalled result changed or dropped");

    // Input cannot stall while the output side is moving and the first stage is empty
    a_no_false_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_out_stall && !stg_valid[1]) |-> !o_in_stall)
        else $error("input stalled on empty pipeline");
`endif

endmodule

`default_nettype wire

// ----- tb/sv/tb_magma_block_cipher_top.sv -----
// Self-checking testbench for magma_block_cipher_top (Magma 64-bit block cipher).
// Depends on mgm_pkg and the RTL; predicts result blocks with its own round model
// and key copy or a pinned table answer, under random idling on both sides.
`default_nettype none

module tb_magma_block_cipher_top;

    localparam logic OP_ENCRYPT = 1'b0;
    localparam logic OP_DECRYPT = 1'b1;

    // First index past the key words; writes at or above it must be dropped
    localparam logic [3:0] FIRST_SPARE_INDEX = 4'd8;

    localparam int TABLE_ROWS      = 12;
    localparam int RANDOM_PHASES   = 6;
    localparam int ITEMS_PER_PHASE = 142;
    localparam int MAX_BURST       = 19;
    localparam int SETTLE_CYCLES   = 40;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int MAX_REPORTS     = 10;

    // Key from the published test vector of the standard
    localparam mgm_pkg::t_key_set STD_KEY = {
        32'hfcfdfeff, 32'hf8f9fafb, 32'hf4f5f6f7, 32'hf0f1f2f3,
        32'h33221100, 32'h77665544, 32'hbbaa9988, 32'hffeeddcc};

    // S-boxes, one 64-bit row per box, entry n at bits [4n+3:4n]
    localparam logic [7:0][63:0] SUBST = {
        64'h2bc96af43850de71, 64'h73ad0b4fc19652e8,
        64'h0e34187bac296fd5, 64'hc24be390d618a5f7,
        64'hb9e35a076f4d128c, 64'h069c471edaf2853b,
        64'hf0db74e1c5a93286, 64'h1f307d8e9b5a264c
    };

    typedef struct packed {
        logic        func;
        logic [63:0] blk;
        logic        pinned;
        logic [63:0] answer;
    } t_vec_row;

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_in_valid     = 1'b0;
    logic        i_func         = 1'b0;
    logic [63:0] i_data_block   = '0;
    logic        i_out_stall    = 1'b0;
    logic        i_cfg_valid    = 1'b0;
    logic [3:0]  i_cfg_index    = '0;
    logic [31:0] i_cfg_data     = '0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [63:0] o_result_block;
    logic        o_cfg_ready;

    // Known answer riding along with the input beat, for table rows that carry one
    logic        drv_pinned     = 1'b0;
    logic [63:0] drv_answer     = '0;

    logic [31:0] round_keys [mgm_pkg::NUM_KEYS];
    logic [63:0] expected_blocks [$];
    t_vec_row    vec_table [TABLE_ROWS];

    int gap_odds    = 0;
    int stall_odds  = 0;
    int stall_left  = 0;
    int cycle_count = 0;
    int blocks_sent = 0;
    int decrypts    = 0;
    int blocks_seen = 0;
    int error_count = 0;
    int key_loads   = 0;

    magma_block_cipher_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_func         (i_func),
        .i_data_block   (i_data_block),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_result_block (o_result_block),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // Round function: add key mod 2^32, substitute nibbles, rotate left by 11
    function automatic logic [31:0] feistel_g(logic [31:0] k, logic [31:0] x);
        logic [31:0] s;
        logic [31:0] t;
        int          i;
        s = x + k;
        for (i = 0; i < 8; i++) begin
            t[4*i +: 4] = SUBST[i][4*s[4*i +: 4] +: 4];
        end
        return {t[20:0], t[31:21]};
    endfunction

    // Run all rounds on one block with the current key copy
    function automatic logic [63:0] magma_cipher(logic dec, logic [63:0] blk);
        logic [31:0] lo;
        logic [31:0] hi;
        logic [31:0] k;
        logic [2:0]  pos;
        logic        fwd;
        int          r;
        lo = blk[31:0];
        hi = blk[63:32];
        for (r = 0; r < mgm_pkg::NUM_ROUNDS; r++) begin
            pos = r[2:0];
            fwd = dec ? (r < 8) : (r < 24);
            k   = round_keys[fwd ? pos : 3'd7 - pos];
            if (r[0] == 1'b0) begin
                hi = hi ^ feistel_g(k, lo);
            end else begin
                lo = lo ^ feistel_g(k, hi);
            end
        end
        return {lo, hi};
    endfunction

    task automatic flag_error(input string what, input logic [63:0] want,
                              input logic [63:0] got);
        error_count++;
        if (error_count <= MAX_REPORTS) begin
            $display("ERROR %s at cycle %0d: expected %h, got %h",
                     what, cycle_count, want, got);
        end
    endtask

    // Track key writes, predict accepted input beats, check output beats
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout: %0d results still pending", expected_blocks.size());
            $display("tb_magma_block_cipher_top: FAIL");
            $finish;
        end else if (!i_rst_n) begin
            for (int i = 0; i < mgm_pkg::NUM_KEYS; i++) begin
                round_keys[i] = '0;
            end
        end else begin
            if (i_cfg_valid && o_cfg_ready && i_cfg_index < mgm_pkg::NUM_KEYS) begin
                round_keys[i_cfg_index[2:0]] = i_cfg_data;
            end
            if (i_in_valid && !o_in_stall) begin
                blocks_sent++;
                if (i_func == OP_DECRYPT) begin
                    decrypts++;
                end
                if (drv_pinned) begin
                    expected_blocks.push_back(drv_answer);
                end else begin
                    expected_blocks.push_back(magma_cipher(i_func, i_data_block));
                end
            end
            if (o_out_valid && !i_out_stall) begin
                blocks_seen++;
                if (expected_blocks.size() == 0) begin
                    flag_error("unexpected result", '0, o_result_block);
                end else begin
                    if (o_result_block !== expected_blocks[0]) begin
                        flag_error("result_block", expected_blocks[0], o_result_block);
                    end
                    void'(expected_blocks.pop_front());
                end
            end
        end
    end

    // Output stall: random bursts whose length is bounded by MAX_BURST, none when stall_odds is 0
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            i_out_stall <= 1'b1;
            stall_left  <= stall_left - 1;
        end else if (i_rst_n && stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
            i_out_stall <= 1'b1;
            stall_left  <= $urandom_range(0, MAX_BURST - 1);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Drive one input beat, hold it until taken, then maybe leave a gap
    task automatic send_block(input logic func, input logic [63:0] blk,
                              input logic pinned, input logic [63:0] answer);
        int gap;
        i_in_valid   <= 1'b1;
        i_func       <= func;
        i_data_block <= blk;
        drv_pinned   <= pinned;
        drv_answer   <= answer;
        do @(posedge i_clk); while (o_in_stall);
        if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
            gap = $urandom_range(1, MAX_BURST);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic walk_table(input logic use_answers);
        int n;
        for (n = 0; n < TABLE_ROWS; n++) begin
            send_block(vec_table[n].func, vec_table[n].blk,
                       use_answers && vec_table[n].pinned, vec_table[n].answer);
        end
        i_in_valid <= 1'b0;
    endtask

    task automatic send_random(input int count);
        logic [63:0] blk;
        int          n;
        for (n = 0; n < count; n++) begin
            case ($urandom_range(0, 9))
                0:       blk = '0;
                1:       blk = '1;
                2:       blk = {32'h0, $urandom()};
                3:       blk = {$urandom(), 32'hffffffff};
                default: blk = {$urandom(), $urandom()};
            endcase
            send_block(1'($urandom_range(0, 1)), blk, 1'b0, '0);
        end
        i_in_valid <= 1'b0;
    endtask

    // Wait until every predicted result has come out
    task automatic drain;
        while (expected_blocks.size() != 0) @(posedge i_clk);
    endtask

    // Write all eight key words, with stray writes past the last key word mixed in
    task automatic load_key(input mgm_pkg::t_key_set words);
        int i;
        for (i = 0; i < mgm_pkg::NUM_KEYS; i++) begin
            if ($urandom_range(0, 2) == 0) begin
                i_cfg_valid <= 1'b1;
                i_cfg_index <= FIRST_SPARE_INDEX + 4'($urandom_range(0, 7));
                i_cfg_data  <= $urandom();
                do @(posedge i_clk); while (!o_cfg_ready);
            end
            i_cfg_valid <= 1'b1;
            i_cfg_index <= mgm_pkg::t_reg_index'(i);
            i_cfg_data  <= words[i];
            do @(posedge i_clk); while (!o_cfg_ready);
        end
        i_cfg_valid <= 1'b0;
        key_loads++;
    endtask

    initial begin
        mgm_pkg::t_key_set key_set;
        int                ph;
        int                i;

        // Extremes, half patterns, both operations; the standard vector pins two rows
        vec_table[0]  = '{OP_ENCRYPT, 64'h0000000000000000, 1'b0, 64'h0};
        vec_table[1]  = '{OP_DECRYPT, 64'h0000000000000000, 1'b0, 64'h0};
        vec_table[2]  = '{OP_ENCRYPT, 64'hffffffffffffffff, 1'b0, 64'h0};
        vec_table[3]  = '{OP_DECRYPT, 64'hffffffffffffffff, 1'b0, 64'h0};
        vec_table[4]  = '{OP_ENCRYPT, 64'h00000000ffffffff, 1'b0, 64'h0};
        vec_table[5]  = '{OP_DECRYPT, 64'hffffffff00000000, 1'b0, 64'h0};
        vec_table[6]  = '{OP_ENCRYPT, 64'h5555555555555555, 1'b0, 64'h0};
        vec_table[7]  = '{OP_DECRYPT, 64'haaaaaaaaaaaaaaaa, 1'b0, 64'h0};
        vec_table[8]  = '{OP_ENCRYPT, 64'h8000000000000001, 1'b0, 64'h0};
        vec_table[9]  = '{OP_ENCRYPT, 64'hfedcba9876543210, 1'b1, 64'h4ee901e5c2d8ca3d};
        vec_table[10] = '{OP_DECRYPT, 64'h4ee901e5c2d8ca3d, 1'b1, 64'hfedcba9876543210};
        vec_table[11] = '{OP_DECRYPT, 64'h0123456789abcdef, 1'b0, 64'h0};

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed rows under the reset key, then under the standard key
        gap_odds   = 4;
        stall_odds = 6;
        walk_table(1'b0);
        drain;
        load_key(STD_KEY);
        walk_table(1'b1);
        drain;

        // Random blocks under a new key per phase; the last phase runs without idling
        for (ph = 0; ph < RANDOM_PHASES; ph++) begin
            for (i = 0; i < mgm_pkg::NUM_KEYS; i++) begin
                case (ph)
                    0:       key_set[i] = '1;
                    2:       key_set[i] = i[0] ? 32'h55555555 : 32'haaaaaaaa;
                    3:       key_set[i] = i[1] ? 32'h0 : $urandom();
                    default: key_set[i] = $urandom();
                endcase
            end
            case (ph)
                0:       begin gap_odds = 3;  stall_odds = 8;  end
                1:       begin gap_odds = 0;  stall_odds = 4;  end
                2:       begin gap_odds = 6;  stall_odds = 0;  end
                3:       begin gap_odds = 12; stall_odds = 12; end
                4:       begin gap_odds = 2;  stall_odds = 3;  end
                default: begin gap_odds = 0;  stall_odds = 0;  end
            endcase
            load_key(key_set);
            send_random(ITEMS_PER_PHASE);
            drain;
        end

        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("%0d blocks in (%0d decrypts), %0d results checked, %0d key loads",
                 blocks_sent, decrypts, blocks_seen, key_loads);
        $display("mismatches and unexpected results: %0d", error_count);
        if (error_count == 0 && expected_blocks.size() == 0) begin
            $display("tb_magma_block_cipher_top: PASS");
        end else begin
            $display("tb_magma_block_cipher_top: FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
